[rtl/core/sbus_frame_decoder_assert.svh]
// Assertion macros shared by the SBUS frame decoder RTL.
`ifndef SBUS_FRAME_DECODER_ASSERT_SVH
`define SBUS_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbus frame decoder assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbus frame decoder assertion failed");

`endif

[rtl/core/sfd_pkg.sv]
// Types and constants of the SBUS frame decoder.
`timescale 1ns / 1ps

package sfd_pkg;

	localparam int CNT_W      = 32;
	localparam int OUT_CNT_W  = 32;
	localparam int FRAME_LEN  = 25;
	localparam int DATA_LEN   = 22;
	localparam int DATA_W     = DATA_LEN * 8;
	localparam int NUM_CH     = 16;
	localparam int CH_W       = 4;
	localparam int RAW_W      = 11;
	localparam int POS_W      = 5;
	localparam int GAIN_W     = 16;
	localparam int OFS_W      = 12;
	localparam int SCALED_W   = 13;
	localparam int PROD_W     = RAW_W + GAIN_W;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [POS_W-1:0] POS_HUNT       = POS_W'(0);
	localparam logic [POS_W-1:0] POS_FIRST_DATA = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LAST_DATA  = POS_W'(DATA_LEN);
	localparam logic [POS_W-1:0] POS_END        = POS_W'(FRAME_LEN - 1);
	localparam logic [CH_W-1:0]  CH_LAST        = CH_W'(NUM_CH - 1);

	localparam logic [7:0]        START_BYTE_RST = 8'd15;
	localparam logic [7:0]        END_BYTE_RST   = 8'd0;
	localparam logic [GAIN_W-1:0] GAIN_RST       = 16'd40945;
	localparam logic [OFS_W-1:0]  OFFSET_RST     = 12'd881;
	localparam logic [PROD_W:0]   ROUND_HALF     = (PROD_W + 1)'(32768);

	typedef enum logic [1:0] {
		KIND_CHAN      = 2'd0,
		KIND_BAD_START = 2'd1,
		KIND_BAD_END   = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_BYTE   = 2'd0,
		CFG_END_BYTE     = 2'd1,
		CFG_SCALE_GAIN   = 2'd2,
		CFG_SCALE_OFFSET = 2'd3
	} cfg_idx_t;

endpackage

[rtl/core/sbus_frame_decoder.sv]
// Rx bytes go in one word per cycle while in_stall is low. A byte that is a frame's last byte
// or a bad hunt byte starts a result sequence: one word for an error, or sixteen channel words
// for a good frame. The byte loads the result sequencer register, from which the first word
// moves into the output register; the words then leave one per cycle unless out_stall holds
// them. While such a sequence drains, the input is stalled until its final word has moved
// into the output register. With no output stall, the end byte of a good frame therefore
// stalls the input while its other channel words drain. Every other byte adds no hold, so a bad
// start or end byte can be followed by another byte in the next cycle. Output stalls lengthen
// that hold.
// Channel scaling is round half up of raw times the Q0.16 gain, plus the offset.
`timescale 1ns / 1ps

`include "sbus_frame_decoder_assert.svh"

module sbus_frame_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          kind,
	output logic [sfd_pkg::CH_W-1:0]            channel_index,
	output logic [sfd_pkg::RAW_W-1:0]           raw_value,
	output logic [sfd_pkg::SCALED_W-1:0]        scaled_value,
	output logic                                last_of_frame,
	output logic [sfd_pkg::OUT_CNT_W-1:0]       good_frames,
	output logic [sfd_pkg::OUT_CNT_W-1:0]       error_frames
);
	import sfd_pkg::*;

	// Configuration registers.
	logic [7:0]        start_byte_q;
	logic [7:0]        end_byte_q;
	logic [GAIN_W-1:0] gain_q;
	logic [OFS_W-1:0]  offset_q;

	// Frame assembly state.
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  good_q;
	logic [CNT_W-1:0]  err_q;

	// Result sequencer.
	logic              em_valid_q;
	kind_t             em_kind_q;
	logic [CH_W-1:0]   em_ch_q;
	logic [DATA_W-1:0] snap_q;

	// Output register.
	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [CH_W-1:0]     out_ch_q;
	logic [RAW_W-1:0]    out_raw_q;
	logic [SCALED_W-1:0] out_scaled_q;
	logic                out_last_q;
	logic [OUT_CNT_W-1:0] out_good_q;
	logic [OUT_CNT_W-1:0] out_err_q;

	logic                in_acc;
	logic                out_load;
	logic                em_last;
	logic                ev_fire;
	kind_t               ev_kind;
	logic [RAW_W-1:0]    cur_raw;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W:0]     rounded;
	logic [SCALED_W-1:0] cur_scaled;

	assign em_last  = (em_kind_q != KIND_CHAN) || (em_ch_q == CH_LAST);
	assign out_load = em_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = em_valid_q && !(out_load && em_last);
	assign in_acc   = in_valid && !in_stall;

	// Decide whether this byte ends in a result sequence.
	always_comb begin
		ev_fire = 1'b0;
		ev_kind = KIND_CHAN;
		if (pos_q == POS_HUNT) begin
			if (rx_byte != start_byte_q) begin
				ev_fire = 1'b1;
				ev_kind = KIND_BAD_START;
			end
		end else if (pos_q == POS_END) begin
			ev_fire = 1'b1;
			ev_kind = (rx_byte != end_byte_q) ? KIND_BAD_END : KIND_CHAN;
		end
	end

	// The snapshot shifts down by one channel per word, so the current channel sits at the bottom.
	assign cur_raw    = snap_q[RAW_W-1:0];
	assign prod       = PROD_W'(cur_raw) * PROD_W'(gain_q);
	assign rounded    = (PROD_W + 1)'(prod) + ROUND_HALF;
	assign cur_scaled = SCALED_W'(rounded[PROD_W:16]) + SCALED_W'(offset_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			end_byte_q   <= END_BYTE_RST;
			gain_q       <= GAIN_RST;
			offset_q     <= OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_BYTE:   start_byte_q <= cfg_data[7:0];
				CFG_END_BYTE:     end_byte_q   <= cfg_data[7:0];
				CFG_SCALE_GAIN:   gain_q       <= cfg_data[GAIN_W-1:0];
				CFG_SCALE_OFFSET: offset_q     <= cfg_data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HUNT;
			good_q <= '0;
			err_q  <= '0;
		end else if (in_acc) begin
			case (pos_q) inside
				POS_HUNT: begin
					if (rx_byte == start_byte_q) begin
						pos_q <= POS_FIRST_DATA;
					end else begin
						err_q <= err_q + CNT_W'(1);
					end
				end
				[POS_FIRST_DATA:POS_END - POS_W'(1)]: begin
					pos_q <= pos_q + POS_W'(1);
				end
				default: begin
					pos_q <= POS_HUNT;
					if (rx_byte == end_byte_q) begin
						good_q <= good_q + CNT_W'(1);
					end else begin
						err_q <= err_q + CNT_W'(1);
					end
				end
			endcase
		end
	end

	// Data bytes enter at the top; after the last one, data byte 1 sits in the lowest lane.
	always_ff @(posedge clk) begin
		if (in_acc && (pos_q >= POS_FIRST_DATA) && (pos_q <= POS_LAST_DATA)) begin
			data_q <= {rx_byte, data_q[DATA_W-1:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_kind_q  <= KIND_CHAN;
			em_ch_q    <= '0;
		end else begin
			if (out_load) begin
				if (em_last) begin
					em_valid_q <= 1'b0;
				end else begin
					em_ch_q <= em_ch_q + CH_W'(1);
				end
			end
			if (in_acc && ev_fire) begin
				em_valid_q <= 1'b1;
				em_kind_q  <= ev_kind;
				em_ch_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && ev_fire) begin
			snap_q <= data_q;
		end else if (out_load) begin
			snap_q <= snap_q >> RAW_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= em_kind_q;
			out_last_q <= em_last;
			out_good_q <= OUT_CNT_W'(good_q);
			out_err_q  <= OUT_CNT_W'(err_q);
			if (em_kind_q == KIND_CHAN) begin
				out_ch_q     <= em_ch_q;
				out_raw_q    <= cur_raw;
				out_scaled_q <= cur_scaled;
			end else begin
				out_ch_q     <= '0;
				out_raw_q    <= '0;
				out_scaled_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign channel_index = out_ch_q;
	assign raw_value     = out_raw_q;
	assign scaled_value  = out_scaled_q;
	assign last_of_frame = out_last_q;
	assign good_frames   = out_good_q;
	assign error_frames  = out_err_q;

	`SFD_ASSERT_NOW(a_pos_range, clk, arst_n, 1'b1, pos_q <= POS_END)
	`SFD_ASSERT_NOW(a_err_word_shape, clk, arst_n, out_valid_q && (out_kind_q != KIND_CHAN),
		out_last_q && (out_ch_q == '0) && (out_raw_q == '0) && (out_scaled_q == '0))
	`SFD_ASSERT_NOW(a_chan_last, clk, arst_n, out_valid_q && (out_kind_q == KIND_CHAN),
		out_last_q == (out_ch_q == CH_LAST))
	`SFD_ASSERT_NEXT(a_chan_follows, clk, arst_n,
		out_valid_q && !out_stall && (out_kind_q == KIND_CHAN) && !out_last_q,
		out_valid_q && (out_kind_q == KIND_CHAN) && (out_ch_q == $past(out_ch_q) + CH_W'(1)))
	`SFD_ASSERT_NOW(a_good_starts_seq, clk, arst_n, !$stable(good_q),
		em_valid_q && (em_kind_q == KIND_CHAN) && (em_ch_q == '0))

endmodule

[tb/sbus_frame_decoder_checker.sv]
// Checker for the SBUS frame decoder: predicts result words from accepted bytes and compares them.
`timescale 1ns / 1ps

module sbus_frame_decoder_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [7:0]                        rx_byte,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [1:0]                        kind,
	input  logic [sfd_pkg::CH_W-1:0]          channel_index,
	input  logic [sfd_pkg::RAW_W-1:0]         raw_value,
	input  logic [sfd_pkg::SCALED_W-1:0]      scaled_value,
	input  logic                              last_of_frame,
	input  logic [sfd_pkg::OUT_CNT_W-1:0]     good_frames,
	input  logic [sfd_pkg::OUT_CNT_W-1:0]     error_frames,
	output int                                mismatches,
	output int                                pending,
	output int                                checked_words,
	output int                                error_words
);
	import sfd_pkg::*;

	typedef struct {
		kind_t                kind;
		logic [CH_W-1:0]      chan;
		logic [RAW_W-1:0]     raw;
		logic [SCALED_W-1:0]  scaled;
		logic                 last;
		logic [31:0]          good;
		logic [31:0]          bad;
	} result_word_t;

	result_word_t decoded_words[$];
	result_word_t want;

	logic [POS_W-1:0]  frame_pos;
	logic [7:0]        frame_data [DATA_LEN];
	logic [31:0]       good_cnt;
	logic [31:0]       bad_cnt;
	logic [7:0]        start_reg;
	logic [7:0]        end_reg;
	logic [GAIN_W-1:0] gain_reg;
	logic [OFS_W-1:0]  offset_reg;

	function automatic result_word_t make_word(kind_t k, logic [CH_W-1:0] ch,
			logic [RAW_W-1:0] raw, logic [SCALED_W-1:0] scaled, logic last);
		result_word_t w;
		w.kind   = k;
		w.chan   = ch;
		w.raw    = raw;
		w.scaled = scaled;
		w.last   = last;
		w.good   = good_cnt;
		w.bad    = bad_cnt;
		return w;
	endfunction

	// Advances the frame position by one byte and queues the words that byte causes.
	task automatic decode_rx(input logic [7:0] b);
		logic [DATA_W-1:0]   packed_data;
		logic [RAW_W-1:0]    raw;
		logic [31:0]         prod;
		logic [SCALED_W-1:0] scaled;
		if (frame_pos == POS_HUNT) begin
			if (b != start_reg) begin
				bad_cnt = bad_cnt + 32'd1;
				decoded_words.push_back(make_word(KIND_BAD_START, '0, '0, '0, 1'b1));
			end else begin
				frame_pos = POS_FIRST_DATA;
			end
		end else if (frame_pos <= POS_LAST_DATA) begin
			frame_data[frame_pos - 1] = b;
			frame_pos = frame_pos + 1'b1;
		end else if (frame_pos < POS_END) begin
			// The flags byte only moves the position along.
			frame_pos = frame_pos + 1'b1;
		end else begin
			frame_pos = POS_HUNT;
			if (b != end_reg) begin
				bad_cnt = bad_cnt + 32'd1;
				decoded_words.push_back(make_word(KIND_BAD_END, '0, '0, '0, 1'b1));
			end else begin
				good_cnt = good_cnt + 32'd1;
				for (int j = 0; j < DATA_LEN; j++)
					packed_data[j*8 +: 8] = frame_data[j];
				for (int ch = 0; ch < NUM_CH; ch++) begin
					raw = packed_data[ch*RAW_W +: RAW_W];
					prod = 32'(raw) * 32'(gain_reg) + 32'd32768;
					scaled = SCALED_W'(prod >> 16) + SCALED_W'(offset_reg);
					decoded_words.push_back(make_word(KIND_CHAN, CH_W'(ch), raw, scaled,
						ch == NUM_CH - 1));
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			frame_pos = POS_HUNT;
			good_cnt = '0;
			bad_cnt = '0;
			start_reg = START_BYTE_RST;
			end_reg = END_BYTE_RST;
			gain_reg = GAIN_RST;
			offset_reg = OFFSET_RST;
			decoded_words.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (decoded_words.size() == 0) begin
					if (mismatches < 10)
						$display("Unexpected result word: kind %0d ch %0d raw %0d",
							kind, channel_index, raw_value);
					mismatches++;
				end else begin
					want = decoded_words.pop_front();
					if (kind !== want.kind || channel_index !== want.chan ||
							raw_value !== want.raw || scaled_value !== want.scaled ||
							last_of_frame !== want.last || good_frames !== want.good ||
							error_frames !== want.bad) begin
						if (mismatches < 10) begin
							$display("Word %0d expected: kind %0d ch %0d raw %0d scaled %0d %s",
								checked_words, want.kind, want.chan, want.raw, want.scaled,
								$sformatf("last %0b good %0d err %0d",
								want.last, want.good, want.bad));
							$display("Word %0d actual:   kind %0d ch %0d raw %0d scaled %0d %s",
								checked_words, kind, channel_index, raw_value, scaled_value,
								$sformatf("last %0b good %0d err %0d",
								last_of_frame, good_frames, error_frames));
						end
						mismatches++;
					end
					if (want.kind != KIND_CHAN)
						error_words++;
					checked_words++;
				end
			end
			if (in_valid && !in_stall)
				decode_rx(rx_byte);
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_START_BYTE:   start_reg = cfg_data[7:0];
					CFG_END_BYTE:     end_reg = cfg_data[7:0];
					CFG_SCALE_GAIN:   gain_reg = cfg_data[GAIN_W-1:0];
					CFG_SCALE_OFFSET: offset_reg = cfg_data[OFS_W-1:0];
					default: ;
				endcase
			end
		end
		pending = decoded_words.size();
	end

endmodule

[tb/sbus_frame_decoder_tb.sv]
// Testbench top for the SBUS frame decoder: clock, reset, byte stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module sbus_frame_decoder_tb;
	import sfd_pkg::*;

	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 200000;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [7:0]               rx_byte;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               kind;
	logic [CH_W-1:0]          channel_index;
	logic [RAW_W-1:0]         raw_value;
	logic [SCALED_W-1:0]      scaled_value;
	logic                     last_of_frame;
	logic [OUT_CNT_W-1:0]     good_frames;
	logic [OUT_CNT_W-1:0]     error_frames;

	int mismatches;
	int pending;
	int checked_words;
	int error_words;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int bytes_sent = 0;
	int cycle_count = 0;
	logic [7:0] cur_start = START_BYTE_RST;
	logic [7:0] cur_end = END_BYTE_RST;

	sbus_frame_decoder i_dut (.*);

	sbus_frame_decoder_checker i_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Output stall: random, except during a requested hold-off that is counted here.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_left = HOLD_CYCLES;
			hold_served = hold_requests;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	function automatic logic [DATA_W-1:0] random_payload();
		logic [DATA_W-1:0] p;
		// Some bytes are all zeros or all ones so channel values reach their extremes.
		for (int i = 0; i < DATA_LEN; i++)
			p[i*8 +: 8] = ($urandom_range(3) == 0) ? {8{1'($urandom)}} : 8'($urandom);
		return p;
	endfunction

	task automatic send_frame(input logic [DATA_W-1:0] payload, input logic [7:0] flags,
			input logic [7:0] last_byte);
		send_byte(cur_start);
		for (int i = 0; i < DATA_LEN; i++)
			send_byte(payload[i*8 +: 8]);
		send_byte(flags);
		send_byte(last_byte);
	endtask

	// Mostly whole frames with random data, some with a bad end byte, some stray bytes.
	task automatic send_random_traffic(input int n_items);
		int target;
		int pick;
		target = bytes_sent + n_items;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 15)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
			else if (pick < 35)
				send_frame(random_payload(), 8'($urandom), cur_end ^ 8'($urandom_range(1, 255)));
			else
				send_frame(random_payload(), 8'($urandom), cur_end);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(input logic [7:0] start_val, input logic [7:0] end_val,
			input logic [GAIN_W-1:0] gain, input logic [OFS_W-1:0] offset);
		write_reg(CFG_START_BYTE, CFG_DATA_W'(start_val));
		write_reg(CFG_END_BYTE, CFG_DATA_W'(end_val));
		write_reg(CFG_SCALE_GAIN, CFG_DATA_W'(gain));
		write_reg(CFG_SCALE_OFFSET, CFG_DATA_W'(offset));
		cur_start = start_val;
		cur_end = end_val;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_START_BYTE;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Two stray bytes while hunting, then a good frame whose first eight channels are
		// all ones and the rest all zeros.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame({{11{8'h00}}, {11{8'hFF}}}, 8'hFF, cur_end);
		drain();

		apply_settings(8'h00, 8'hFF, 16'hFFFF, 12'hFFF);
		send_idle_pct = 52;
		send_frame(random_payload(), 8'h00, ~cur_end);
		send_random_traffic(30);
		drain();

		apply_settings(8'hFF, 8'h00, 16'h0000, 12'h000);
		send_idle_pct = 0;
		stall_pct = 52;
		send_random_traffic(20);
		drain();
		send_random_traffic(15);
		drain();

		apply_settings(START_BYTE_RST, END_BYTE_RST, 16'($urandom), 12'($urandom));
		send_idle_pct = 27;
		stall_pct = 27;
		// Hold the output while two frames come in, so the decoder backs up into its input.
		hold_requests++;
		send_frame(random_payload(), 8'($urandom), cur_end);
		send_frame(random_payload(), 8'($urandom), cur_end);
		send_random_traffic(15);
		drain();

		$display("Summary: %0d rx bytes sent, %0d result words checked, %0d of them errors.",
			bytes_sent, checked_words, error_words);
		$display("Four register settings and idle/stall mixes, plus one long output hold-off.");
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d words outstanding", cycle_count, pending);
		$display("Some tests failed");
		$finish;
	end

endmodule
